FILE: sv/sst_pkg.sv
// sst_pkg: shared constants and types for the shell-style tokenizer.
// Used by shell_style_tokenizer and its checker; depends on nothing.
`default_nettype none

package sst_pkg;

    // Special characters
    localparam logic [7:0] BACKSLASH_CHAR = 8'h5C;
    localparam logic [7:0] DQUOTE_CHAR    = 8'h22;
    localparam logic [7:0] SQUOTE_CHAR    = 8'h27;
    localparam logic [7:0] SPACE_CHAR     = 8'h20;
    localparam logic [7:0] TAB_CHAR       = 8'h09;
    localparam logic [7:0] CR_CHAR        = 8'h0D;

    // Result kinds (travel on tuser)
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Result queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_RESULTS = 2;

    // One result request
    typedef struct packed {
        logic       kind;
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_result;

    // True for space, tab, newline, vertical tab, form feed, carriage return
    function automatic logic is_blank(input logic [7:0] b);
        return (b == SPACE_CHAR) || ((b >= TAB_CHAR) && (b <= CR_CHAR));
    endfunction

endpackage

`default_nettype wire

FILE: sv/shell_style_tokenizer.sv
// shell_style_tokenizer: splits a command line stream into token bytes and token ends.
// Depends on sst_pkg for character codes, result type and queue sizes.
`default_nettype none

// Usage
//   Slave side: one command-line character per request on tdata; tlast marks
//   the final byte of a line. Master side: one result per request; tdata is a
//   token byte, tuser is 0 for a token byte and 1 for a token end (tdata then
//   zero), tlast marks the final result caused by one input byte.
//   An input byte gives zero, one or two results (a byte and/or a token end).
//   The results of a byte enter the result queue when the byte is accepted.
//   Throughput: one byte per cycle while each byte gives at most one result and
//   the receiver keeps up; a byte with two results needs two master transfers.
//   The rate is set by the four-entry result queue between the tokenizer
//   state logic and the master side: the slave side is ready whenever the
//   queue has room for two results, a registered condition, so tready never
//   depends on the master side's tready in the same cycle.
//   When the receiver stalls, results collect in the queue and the slave
//   side drops tready once fewer than two entries are free.
//   Reset (i_rst_n low, synchronous) clears the escape, quote and token
//   flags and empties the queue. The end of a line also returns the
//   tokenizer flags to their reset values after closing an open token.

module shell_style_tokenizer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Slave side
    input  wire logic       i_s_axis_tvalid,
    output      logic       o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  wire logic       i_s_axis_tlast,   // end_of_line
    // Master side
    output      logic       o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output      logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output      logic       o_m_axis_tuser,   // kind
    output      logic       o_m_axis_tlast    // last_of_run
);
    import sst_pkg::*;

    // Tokenizer flags
    logic r_escape_pending, n_escape_pending;
    logic r_inside_quote,   n_inside_quote;
    logic r_quote_single,   n_quote_single;
    logic r_token_open,     n_token_open;

    // Result queue
    t_result               r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]     r_count,  n_count;

    logic                  in_fire;
    logic                  out_fire;
    logic [7:0]            b;
    logic                  emit_byte;
    logic                  emit_end;
    logic                  tok_mid;
    logic [1:0]            n_results;
    t_result               res0;
    t_result               res1;
    logic [QPTR_W-1:0]     wr_ptr1;

    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_fire = o_m_axis_tvalid && i_m_axis_tready;
    assign b        = i_s_axis_tdata;

    // Per-byte state update and result generation
    always_comb begin
        n_escape_pending = r_escape_pending;
        n_inside_quote   = r_inside_quote;
        n_quote_single   = r_quote_single;
        tok_mid          = r_token_open;
        emit_byte        = 1'b0;
        emit_end         = 1'b0;

        priority if (r_escape_pending) begin
            n_escape_pending = 1'b0;
            tok_mid          = 1'b1;
            emit_byte        = 1'b1;
        end else if (b == BACKSLASH_CHAR) begin
            n_escape_pending = 1'b1;
        end else if ((b == DQUOTE_CHAR) || (b == SQUOTE_CHAR)) begin
            if (r_inside_quote) begin
                if ((b == SQUOTE_CHAR) == r_quote_single) begin
                    n_inside_quote = 1'b0;
                    n_quote_single = 1'b0;
                end else begin
                    // other quote is literal inside a span
                    tok_mid   = 1'b1;
                    emit_byte = 1'b1;
                end
            end else begin
                n_inside_quote = 1'b1;
                n_quote_single = (b == SQUOTE_CHAR);
            end
        end else if (is_blank(b) && !r_inside_quote) begin
            if (r_token_open) begin
                tok_mid  = 1'b0;
                emit_end = 1'b1;
            end
        end else begin
            tok_mid   = 1'b1;
            emit_byte = 1'b1;
        end

        n_token_open = tok_mid;

        // End of line closes an open token and clears all flags
        if (i_s_axis_tlast) begin
            if (tok_mid) begin
                emit_end = 1'b1;
            end
            n_escape_pending = 1'b0;
            n_inside_quote   = 1'b0;
            n_quote_single   = 1'b0;
            n_token_open     = 1'b0;
        end
    end

    // Pack results: a byte always comes before a token end
    always_comb begin
        n_results = {1'b0, emit_byte} + {1'b0, emit_end};
        if (emit_byte) begin
            res0 = '{kind: KIND_BYTE, out_byte: b, last_of_run: !emit_end};
        end else begin
            res0 = '{kind: KIND_END, out_byte: 8'h00, last_of_run: 1'b1};
        end
        res1 = '{kind: KIND_END, out_byte: 8'h00, last_of_run: 1'b1};
    end

    assign wr_ptr1 = r_wr_ptr + QPTR_W'(1);

    // Queue pointer and count updates
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (in_fire) begin
            n_wr_ptr = r_wr_ptr + QPTR_W'(n_results);
            n_count  = n_count + QCNT_W'(n_results);
        end
        if (out_fire) begin
            n_rd_ptr = r_rd_ptr + QPTR_W'(1);
            n_count  = n_count - QCNT_W'(1);
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape_pending <= 1'b0;
            r_inside_quote   <= 1'b0;
            r_quote_single   <= 1'b0;
            r_token_open     <= 1'b0;
            r_wr_ptr         <= '0;
            r_rd_ptr         <= '0;
            r_count          <= '0;
        end else begin
            if (in_fire) begin
                r_escape_pending <= n_escape_pending;
                r_inside_quote   <= n_inside_quote;
                r_quote_single   <= n_quote_single;
                r_token_open     <= n_token_open;
            end
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (in_fire && (n_results != 2'd0)) begin
            r_queue[r_wr_ptr] <= res0;
        end
        if (in_fire && (n_results == 2'(MAX_RESULTS))) begin
            r_queue[wr_ptr1] <= res1;
        end
    end

    // Ports
    assign o_s_axis_tready = (r_count <= QCNT_W'(QUEUE_DEPTH - MAX_RESULTS));
    assign o_m_axis_tvalid = (r_count != '0);
    assign o_m_axis_tdata  = r_queue[r_rd_ptr].out_byte;
    assign o_m_axis_tuser  = r_queue[r_rd_ptr].kind;
    assign o_m_axis_tlast  = r_queue[r_rd_ptr].last_of_run;

endmodule

`default_nettype wire

FILE: sv/sst_checker.sv
// sst_checker: port-level assertions for shell_style_tokenizer, bound to that module.
// Depends on sst_pkg for result kind codes.
`default_nettype none

module sst_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_s_axis_tready,
    input wire logic       o_m_axis_tvalid,
    input wire logic       i_m_axis_tready,
    input wire logic [7:0] o_m_axis_tdata,
    input wire logic       o_m_axis_tuser,
    input wire logic       o_m_axis_tlast
);
    import sst_pkg::*;

    logic r_prev_end;
    logic out_fire;

    assign out_fire = o_m_axis_tvalid && i_m_axis_tready;

    // Last delivered result was a token end (or nothing since reset)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_end <= 1'b1;
        end else if (out_fire) begin
            r_prev_end <= (o_m_axis_tuser == KIND_END);
        end
    end

    // A token end carries zero data and is always the final result of its byte
    a_end_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == KIND_END)) |->
            (o_m_axis_tlast && (o_m_axis_tdata == 8'h00)))
        else $error("token end with data or without tlast");

    // Empty tokens are never reported
    a_no_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && (o_m_axis_tuser == KIND_END)) |-> !r_prev_end)
        else $error("token end without token bytes");

    // Reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result shown right after reset");

    // An empty result queue always takes a request
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("slave side not ready with empty queue");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
             && $stable(o_m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind shell_style_tokenizer sst_checker u_sst_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

`default_nettype wire
